// File: rtl/kscc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscc_pkg
// Shared types and constants for the canonical k-mer shifter.
// ----------------------------------------------------------------------------
package kscc_pkg;

   localparam int MAX_KMER_DEFAULT = 32;
   localparam int BITS_PER_CODE    = 2;
   localparam int KMER_W           = 64;          // packed k-mer word
   localparam int KMER_POS         = KMER_W / BITS_PER_CODE;
   localparam int KLEN_W           = 6;
   localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd32;
   localparam int REQ_DATA_W       = 8;
   localparam int RSP_DATA_W       = 2 * KMER_W;

   typedef logic [BITS_PER_CODE-1:0] code_type;

   typedef enum logic {
      CMD_CHILD  = 1'b0,   // append at end
      CMD_PARENT = 1'b1    // prepend at front
   } cmd_type;

   typedef struct packed {
      logic    shift;
      cmd_type cmd;
      code_type code;
   } cell_ctrl_type;

endpackage

// File: rtl/kscc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscc_cell
// One nucleotide position of the k-mer shift chain.
// ----------------------------------------------------------------------------
module kscc_cell #(
   parameter int POS = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kscc_pkg::cell_ctrl_type  ctrl,
   input  logic                     in_range,   // POS < k
   input  logic                     is_last,    // POS == k-1
   input  kscc_pkg::code_type       up_code,    // neighbor POS+1
   input  kscc_pkg::code_type       down_code,  // neighbor POS-1
   output kscc_pkg::code_type       code
);

   kscc_pkg::code_type code_ff, code_in;

   always_comb begin
      code_in = code_ff;
      if (ctrl.shift) begin
         if (ctrl.cmd == kscc_pkg::CMD_CHILD) begin
            if (is_last) begin
               code_in = ctrl.code;
            end else if (in_range) begin
               code_in = up_code;
            end else begin
               code_in = '0;
            end
         end else begin
            if (POS == 0) begin
               code_in = ctrl.code;
            end else if (in_range) begin
               code_in = down_code;
            end else begin
               code_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
      end else begin
         code_ff <= code_in;
      end
   end

   assign code = code_ff;

endmodule

// File: rtl/kmer_shift_revcomp_canonical.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_shift_revcomp_canonical
// Two-bit k-mer shift register with reverse complement and canonical flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_* stream: one transaction per nucleotide. req_tuser[0] is the command
//     (0 child: append at end, 1 parent: prepend at front), req_tdata[1:0]
//     the nucleotide code (A C G T = 0..3).
//   rsp_* stream: one transaction per request. rsp_tdata[63:0] is the packed
//     k-mer after the step, rsp_tdata[127:64] its reverse complement;
//     rsp_tuser[0] is set when the k-mer is canonical.
//   csr_wr_en/csr_wr_data write kmer_length (0 acts as 1, above MAX_KMER
//     acts as MAX_KMER). Write only while the block is empty.
// Stages, in order: cell chain update, reverse-complement stage and
//   compare/output stage; a request moves through each stage register in
//   turn, and rsp_tvalid is the valid of the last one.
// Throughput: one transaction per cycle unless a held response stalls it;
//   the chain shifts once per accepted request; each later stage holds one.
// Stall: every stage has its own valid; a held response only stops the
//   stages behind it once they are full, so up to two more requests are
//   taken while a response waits.
// Reset: k-mer cleared to all A, kmer_length back to 32, pipeline empty.
// ----------------------------------------------------------------------------
module kmer_shift_revcomp_canonical #(
   parameter int MAX_KMER = kscc_pkg::MAX_KMER_DEFAULT   // 1..32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = nucleotide_code[1:0], pad[7:2]; tuser = cmd[0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [kscc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   // response: tdata = forward_kmer[63:0], revcomp_kmer[127:64];
   //           tuser = canonical_flag[0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kscc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   // kmer_length register
   input  logic                              csr_wr_en,
   input  logic [kscc_pkg::KLEN_W-1:0]       csr_wr_data
);

   localparam int KW  = kscc_pkg::KMER_W;
   localparam int BPC = kscc_pkg::BITS_PER_CODE;
   localparam int NP  = kscc_pkg::KMER_POS;
   localparam int LW  = kscc_pkg::KLEN_W;
   localparam int IDX_W = (MAX_KMER > 1) ? $clog2(MAX_KMER) : 1;

   // ---- configuration ----
   logic [LW-1:0] klen_ff, klen_in;
   logic [LW-1:0] k_eff;

   always_comb begin
      klen_in = csr_wr_en ? csr_wr_data : klen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= kscc_pkg::KLEN_RESET;
      end else begin
         klen_ff <= klen_in;
      end
   end

   always_comb begin
      if (klen_ff == '0) begin
         k_eff = LW'(1);
      end else if (klen_ff > LW'(MAX_KMER)) begin
         k_eff = LW'(MAX_KMER);
      end else begin
         k_eff = klen_ff;
      end
   end

   // ---- handshake across the three stages ----
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rdy2, rdy3, req_acc;

   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign req_tready = !v1_ff || rdy2;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      v1_in = req_acc ? 1'b1 : (rdy2 ? 1'b0 : v1_ff);
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ---- stage 1: chain of cells, one per position ----
   kscc_pkg::cell_ctrl_type ctrl;
   kscc_pkg::code_type      cell_code [MAX_KMER];
   logic [KW-1:0]           fwd_word;

   assign ctrl.shift = req_acc;
   assign ctrl.cmd   = kscc_pkg::cmd_type'(req_tuser);
   assign ctrl.code  = req_tdata[BPC-1:0];

   for (genvar i = 0; i < MAX_KMER; i++) begin : g_cell
      kscc_pkg::code_type up_c, down_c;
      if (i == MAX_KMER - 1) begin : g_top
         assign up_c = '0;
      end else begin : g_mid
         assign up_c = cell_code[i+1];
      end
      if (i == 0) begin : g_bot
         assign down_c = '0;
      end else begin : g_nbot
         assign down_c = cell_code[i-1];
      end

      kscc_cell #(.POS(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .in_range  (LW'(i) < k_eff),
         .is_last   (LW'(i + 1) == k_eff),
         .up_code   (up_c),
         .down_code (down_c),
         .code      (cell_code[i])
      );
   end

   always_comb begin
      fwd_word = '0;
      for (int i = 0; i < MAX_KMER; i++) begin
         fwd_word[BPC*i +: BPC] = cell_code[i];
      end
   end

   // ---- stage 2: reverse complement over k positions ----
   logic [KW-1:0] fwd2_ff, rc2_ff, rc_word;

   always_comb begin
      logic [LW-1:0] src;
      rc_word = '0;
      for (int j = 0; j < MAX_KMER; j++) begin
         src = k_eff - LW'(1) - LW'(j);
         if (LW'(j) < k_eff) begin
            rc_word[BPC*j +: BPC] = ~cell_code[src[IDX_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         fwd2_ff <= fwd_word;
         rc2_ff  <= rc_word;
      end
   end

   // ---- stage 3: lexicographic compare from position 0, output register ----
   // Position 0 is placed in the top bits so an unsigned compare gives the
   // lexicographic order. Unused positions are zero in both words.
   logic [KW-1:0] fwd_lex, rc_lex;
   logic [KW-1:0] fwd3_ff, rc3_ff;
   logic          canon3_ff;

   always_comb begin
      for (int i = 0; i < NP; i++) begin
         fwd_lex[KW-1-BPC*i -: BPC] = fwd2_ff[BPC*i +: BPC];
         rc_lex [KW-1-BPC*i -: BPC] = rc2_ff [BPC*i +: BPC];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         fwd3_ff   <= fwd2_ff;
         rc3_ff    <= rc2_ff;
         canon3_ff <= (fwd_lex <= rc_lex);
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {rc3_ff, fwd3_ff};
   assign rsp_tuser  = canon3_ff;

endmodule

// File: rtl/kscc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kscc_checker
// Port-level checks for the canonical k-mer shifter.
// ----------------------------------------------------------------------------
module kscc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [kscc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);

   localparam int KW = kscc_pkg::KMER_W;

   // held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // palindrome is always canonical
   a_palindrome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[KW-1:0] == rsp_tdata[2*KW-1:KW]) |-> rsp_tuser)
      else $error("palindromic k-mer not flagged canonical");

   // k >= 1, so forward and reverse complement cannot both be all zero
   a_not_both_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[KW-1:0] != '0) || (rsp_tdata[2*KW-1:KW] != '0))
      else $error("forward and reverse complement both zero");

endmodule

bind kmer_shift_revcomp_canonical kscc_checker u_kscc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
